// ===== rtl/core/pfcba_pkg.sv =====
// Shared types, register map and default constants for the PFC buffer admission unit.
package pfcba_pkg;

  localparam int NUM_PORTS_DEF  = 64;
  localparam int NUM_PRIOS_DEF  = 8;
  localparam int COUNT_W_DEF    = 24;

  localparam int CFG_W          = 24;
  localparam int PROB_W         = 17;
  localparam int DRAW_W         = 16;
  localparam int PORT_W         = 6;
  localparam int PRIO_W         = 3;
  localparam int PKT_W          = 14;
  localparam int IDX_W          = PORT_W + PRIO_W;

  localparam int S_TDATA_W      = 48;
  localparam int M_TDATA_W      = 8;
  localparam int APB_ADDR_W     = 5;
  localparam int APB_DATA_W     = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_RESERVED  = 3'd0;
  localparam logic [2:0] REG_PAUSE_THR = 3'd1;
  localparam logic [2:0] REG_RESUME    = 3'd2;
  localparam logic [2:0] REG_HDRM_LIM  = 3'd3;
  localparam logic [2:0] REG_ECN_MIN   = 3'd4;
  localparam logic [2:0] REG_ECN_MAX   = 3'd5;
  localparam logic [2:0] REG_ECN_PROB  = 3'd6;

  // Register reset values
  localparam logic [CFG_W-1:0] PAUSE_THR_RST = CFG_W'(1048 * 5 + 1);
  localparam logic [CFG_W-1:0] RESUME_RST    = CFG_W'(9 * 1024);
  localparam logic [CFG_W-1:0] ECN_MAX_RST   = {CFG_W{1'b1}};

  typedef struct packed {
    logic [CFG_W-1:0]  reserved;
    logic [CFG_W-1:0]  pause_thr;
    logic [CFG_W-1:0]  resume_off;
    logic [CFG_W-1:0]  hdrm_limit;
    logic [CFG_W-1:0]  ecn_min;
    logic [CFG_W-1:0]  ecn_max;
    logic [PROB_W-1:0] ecn_prob;
  } cfg_t;

  typedef struct packed {
    logic              force_mark;  // egress above max depth
    logic              test;        // egress between min and max: RED draw decides
    logic [CFG_W-1:0]  span;
    logic [CFG_W-1:0]  depth;
    logic [DRAW_W-1:0] draw;
    logic [PROB_W-1:0] prob;
  } ecn_req_t;

endpackage

// ===== rtl/core/pfcba_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module pfcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pfcba_regs.sv =====
// APB configuration registers for the PFC buffer admission unit.
module pfcba_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pfcba_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pfcba_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pfcba_pkg::APB_DATA_W-1:0]   prdata,
  output logic                               pready,
  output pfcba_pkg::cfg_t                    cfg
);
  import pfcba_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reserved   <= '0;
      cfg.pause_thr  <= PAUSE_THR_RST;
      cfg.resume_off <= RESUME_RST;
      cfg.hdrm_limit <= '0;
      cfg.ecn_min    <= '0;
      cfg.ecn_max    <= ECN_MAX_RST;
      cfg.ecn_prob   <= '0;
    end else if (wr) begin
      case (idx)
        REG_RESERVED:  cfg.reserved   <= pwdata[CFG_W-1:0];
        REG_PAUSE_THR: cfg.pause_thr  <= pwdata[CFG_W-1:0];
        REG_RESUME:    cfg.resume_off <= pwdata[CFG_W-1:0];
        REG_HDRM_LIM:  cfg.hdrm_limit <= pwdata[CFG_W-1:0];
        REG_ECN_MIN:   cfg.ecn_min    <= pwdata[CFG_W-1:0];
        REG_ECN_MAX:   cfg.ecn_max    <= pwdata[CFG_W-1:0];
        REG_ECN_PROB:  cfg.ecn_prob   <= pwdata[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RESERVED:  prdata = APB_DATA_W'(cfg.reserved);
      REG_PAUSE_THR: prdata = APB_DATA_W'(cfg.pause_thr);
      REG_RESUME:    prdata = APB_DATA_W'(cfg.resume_off);
      REG_HDRM_LIM:  prdata = APB_DATA_W'(cfg.hdrm_limit);
      REG_ECN_MIN:   prdata = APB_DATA_W'(cfg.ecn_min);
      REG_ECN_MAX:   prdata = APB_DATA_W'(cfg.ecn_max);
      REG_ECN_PROB:  prdata = APB_DATA_W'(cfg.ecn_prob);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/pfcba_ecn.sv =====
// RED marking decision: registered products of draw*span and prob*depth, then compare.
module pfcba_ecn (
  input  logic                  clk,
  input  logic                  load,
  input  pfcba_pkg::ecn_req_t   req,
  output logic                  mark
);
  import pfcba_pkg::*;

  localparam int PA_W = DRAW_W + CFG_W;
  localparam int PB_W = PROB_W + CFG_W;

  logic [PA_W-1:0] prod_a;
  logic [PB_W-1:0] prod_b;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_a <= PA_W'(req.draw) * PA_W'(req.span);
      prod_b <= PB_W'(req.prob) * PB_W'(req.depth);
    end
  end

  assign mark = req.force_mark | (req.test & (PB_W'(prod_a) < prod_b));

endmodule

// ===== rtl/core/pfc_buffer_admission_ecn_unit.sv =====
// Top level of the PFC buffer admission unit with RED/ECN marking.
// An input transfer is read, then updated (CALC), evaluated (EVAL) and multiplied (MULT);
//   FIN then loads m_tdata and raises m_tvalid, holding while a previous result waits.
//   The counter read-modify-write and the ECN multiply keep one item in flight at a time.
// Reset (rst, synchronous): registers take their defaults, then a clearing pass zeroes
//   all NUM_PORTS*NUM_PRIORITIES slots (512 by default) of both counter memories with s_tready low.
module pfc_buffer_admission_ecn_unit #(
  parameter int NUM_PORTS      = pfcba_pkg::NUM_PORTS_DEF,
  parameter int NUM_PRIORITIES = pfcba_pkg::NUM_PRIOS_DEF,
  parameter int COUNT_WIDTH    = pfcba_pkg::COUNT_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata from bit 0: in_port[5:0], out_port[11:6], priority_req[14:12],
  //   packet_bytes[28:15], random_draw[44:29], zero fill [47:45]
  input  logic [pfcba_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: command (0 arrival, 1 departure)
  input  logic                              s_tuser,
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata from bit 0: admitted, send_pause, send_resume, ecn_mark, zero fill [7:4]
  output logic [pfcba_pkg::M_TDATA_W-1:0]   m_tdata,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pfcba_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pfcba_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pfcba_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import pfcba_pkg::*;

  localparam int NUM_SLOTS = NUM_PORTS * NUM_PRIORITIES;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CW        = COUNT_WIDTH;
  // Arithmetic width: room for counter or config value plus a carry and a compare bit
  localparam int AW        = ((CW > CFG_W) ? CW : CFG_W) + 2;
  localparam int A_W       = 2 * CW + 1;   // {pause_flag, headroom, ingress}

  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_MULT  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  cfg_t cfg;

  pfcba_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  logic [2:0]        state;
  logic [SLOT_W-1:0] clr_addr;
  logic              clearing;
  logic              clr_last;
  logic              accept;
  logic              out_free;
  logic              out_load;

  assign clearing = (state == ST_CLEAR);
  assign clr_last = (clr_addr == SLOT_W'(NUM_SLOTS - 1));
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign out_load = (state == ST_FIN) & out_free;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic [PORT_W-1:0] in_port;
  logic [PORT_W-1:0] out_port;
  logic [PRIO_W-1:0] prio;
  logic [PKT_W-1:0]  pkt_bytes;
  logic [DRAW_W-1:0] draw;
  logic [IDX_W-1:0]  in_idx;
  logic [IDX_W-1:0]  out_idx;
  logic              in_range;

  assign in_port   = s_tdata[5:0];
  assign out_port  = s_tdata[11:6];
  assign prio      = s_tdata[14:12];
  assign pkt_bytes = s_tdata[28:15];
  assign draw      = s_tdata[44:29];

  assign in_idx  = IDX_W'(in_port) * IDX_W'(NUM_PRIORITIES) + IDX_W'(prio);
  assign out_idx = IDX_W'(out_port) * IDX_W'(NUM_PRIORITIES) + IDX_W'(prio);

  // Out-of-range items touch no state
  assign in_range = ({3'b000, in_port} < 9'(NUM_PORTS)) &&
                    ({3'b000, out_port} < 9'(NUM_PORTS)) &&
                    ({1'b0, prio} < 4'(NUM_PRIORITIES));

  // Item held for the whole update
  logic              cmd_q;
  logic              valid_q;
  logic [PRIO_W-1:0] prio_q;
  logic [PKT_W-1:0]  psz_q;
  logic [DRAW_W-1:0] draw_q;
  logic [SLOT_W-1:0] in_slot_q;
  logic [SLOT_W-1:0] out_slot_q;

  // ---------------------------------------------------------------------------
  // Counter memories: A holds ingress/headroom/pause per ingress slot,
  // B holds egress bytes per egress slot.
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [SLOT_W-1:0] a_waddr;
  logic [SLOT_W-1:0] b_waddr;
  logic [A_W-1:0]    a_wdata;
  logic [CW-1:0]     b_wdata;
  logic [A_W-1:0]    a_rdata;
  logic [CW-1:0]     b_rdata;
  logic              wr_en;
  logic              pf_new;

  logic [CW-1:0]     ing_n;
  logic [CW-1:0]     hdr_n;
  logic [CW-1:0]     egr_n;

  assign ram_we  = clearing | ((state == ST_EVAL) & wr_en);
  assign a_waddr = clearing ? clr_addr : in_slot_q;
  assign b_waddr = clearing ? clr_addr : out_slot_q;
  assign a_wdata = clearing ? '0 : {pf_new, hdr_n, ing_n};
  assign b_wdata = clearing ? '0 : egr_n;

  pfcba_ram #(.WIDTH(A_W), .DEPTH(NUM_SLOTS)) u_ram_ing (
    .clk   (clk),
    .we    (ram_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .re    (accept),
    .raddr (SLOT_W'(in_idx)),
    .rdata (a_rdata)
  );

  pfcba_ram #(.WIDTH(CW), .DEPTH(NUM_SLOTS)) u_ram_egr (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (accept),
    .raddr (SLOT_W'(out_idx)),
    .rdata (b_rdata)
  );

  // ---------------------------------------------------------------------------
  // Update: new counter values from the read data (CALC)
  // ---------------------------------------------------------------------------
  logic [CW-1:0] ing;
  logic [CW-1:0] hdr;
  logic          pf_q;
  logic [AW-1:0] ing_x, hdr_x, egr_x, psz_x;
  logic [AW-1:0] rsv_x, thr_x, hlim_x, roff_x, rt_x, max_x;
  logic [AW-1:0] nb_x, hsum_x, esum_x, ih_x, ih_diff, e_diff, h_diff;
  logic [CW-1:0] nb_sat, h_sat, e_sat;
  logic          hdrm_over, shared_over, goes_hr, admit_c;
  logic [CW-1:0] ing_c, hdr_c, egr_c;
  logic          admit_q;

  assign ing   = a_rdata[CW-1:0];
  assign hdr   = a_rdata[2*CW-1:CW];

  assign ing_x  = AW'(ing);
  assign hdr_x  = AW'(hdr);
  assign egr_x  = AW'(b_rdata);
  assign psz_x  = AW'(psz_q);
  assign rsv_x  = AW'(cfg.reserved);
  assign thr_x  = AW'(cfg.pause_thr);
  assign hlim_x = AW'(cfg.hdrm_limit);
  assign roff_x = AW'(cfg.resume_off);
  assign rt_x   = rsv_x + thr_x;           // reserve plus pause threshold
  assign max_x  = AW'(CNT_MAX);

  assign nb_x   = ing_x + psz_x;
  assign hsum_x = hdr_x + psz_x;
  assign esum_x = egr_x + psz_x;
  assign nb_sat = (nb_x > max_x) ? CNT_MAX : nb_x[CW-1:0];
  assign h_sat  = (hsum_x > max_x) ? CNT_MAX : hsum_x[CW-1:0];
  assign e_sat  = (esum_x > max_x) ? CNT_MAX : esum_x[CW-1:0];

  // Shared use is ingress over the reserve; compare against reserve + threshold instead
  assign hdrm_over   = hsum_x > hlim_x;
  assign shared_over = (ing_x > rsv_x) ? (nb_x > rt_x) : (psz_x > thr_x);
  assign goes_hr     = nb_x > rt_x;
  assign admit_c     = ~(hdrm_over & shared_over);

  // Departure: drain headroom first, then ingress; clamp at zero
  assign ih_x    = ing_x + hdr_x;
  assign h_diff  = hdr_x - psz_x;
  assign ih_diff = ih_x - psz_x;
  assign e_diff  = egr_x - psz_x;

  always_comb begin
    if (cmd_q) begin
      if (hdr_x >= psz_x) begin
        hdr_c = h_diff[CW-1:0];
        ing_c = ing;
      end else begin
        hdr_c = '0;
        ing_c = (ih_x > psz_x) ? ih_diff[CW-1:0] : '0;
      end
      egr_c = (egr_x > psz_x) ? e_diff[CW-1:0] : '0;
    end else begin
      hdr_c = goes_hr ? h_sat : hdr;
      ing_c = goes_hr ? ing : nb_sat;
      egr_c = e_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Evaluate: pause / resume, write-back value, ECN request (EVAL)
  // ---------------------------------------------------------------------------
  logic [AW-1:0] ingn_x, egn_x, emin_x, emax_x, dep_diff;
  logic          pause_c, resume_c, ecn_on, above_max;
  logic          res_admit, res_pause, res_resume;
  ecn_req_t      ecn_req;
  logic          ecn_mark;

  assign ingn_x   = AW'(ing_n);
  assign egn_x    = AW'(egr_n);
  assign emin_x   = AW'(cfg.ecn_min);
  assign emax_x   = AW'(cfg.ecn_max);
  assign dep_diff = egn_x - emin_x;

  assign pause_c  = ~cmd_q & valid_q & admit_q & ~pf_q &
                    ((hdr_n != '0) || (thr_x == '0) || (ingn_x >= rt_x));
  assign resume_c = cmd_q & valid_q & pf_q & (hdr_n == '0) &
                    ((ingn_x <= rsv_x) || (ingn_x + roff_x <= rt_x));
  assign wr_en    = valid_q & (cmd_q | admit_q);
  assign pf_new   = cmd_q ? (pf_q & ~resume_c) : (pf_q | pause_c);

  // Priority 0 never marks
  assign ecn_on    = valid_q & cmd_q & (prio_q != '0);
  assign above_max = egn_x > emax_x;

  pfcba_ecn u_ecn (
    .clk  (clk),
    .load (state == ST_MULT),
    .req  (ecn_req),
    .mark (ecn_mark)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: state <= ST_EVAL;
        ST_EVAL: state <= ST_MULT;
        ST_MULT: state <= ST_FIN;
        ST_FIN: begin
          // hold while the previous result is still waiting
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= s_tuser;
      valid_q    <= in_range;
      prio_q     <= prio;
      psz_q      <= pkt_bytes;
      draw_q     <= draw;
      in_slot_q  <= SLOT_W'(in_idx);
      out_slot_q <= SLOT_W'(out_idx);
    end
    if (state == ST_CALC) begin
      ing_n   <= ing_c;
      hdr_n   <= hdr_c;
      egr_n   <= egr_c;
      pf_q    <= a_rdata[2*CW];
      admit_q <= admit_c;
    end
    if (state == ST_EVAL) begin
      res_admit          <= cmd_q | (valid_q & admit_q);
      res_pause          <= pause_c;
      res_resume         <= resume_c;
      ecn_req.force_mark <= ecn_on & above_max;
      ecn_req.test       <= ecn_on & ~above_max & (egn_x > emin_x);
      ecn_req.span       <= cfg.ecn_max - cfg.ecn_min;
      ecn_req.depth      <= dep_diff[CFG_W-1:0];
      ecn_req.draw       <= draw_q;
      ecn_req.prob       <= cfg.ecn_prob;
    end
    if (out_load) begin
      m_tdata <= {4'b0000, ecn_mark, res_resume, res_pause, res_admit};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CALC))
    else $error("transfer accepted but update did not start");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && m_tvalid && !m_tready) |=> (state == ST_FIN))
    else $error("result dropped while output register was full");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_EVAL || state == ST_CLEAR))
    else $error("counter memory written outside write-back or clearing");

  a_drop_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && !cmd_q && !admit_q) |-> !ram_we)
    else $error("dropped arrival changed counter state");

  a_pause_resume_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
    else $error("pause and resume raised for one item");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the PFC buffer admission unit with RED/ECN marking.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pfcba_pkg::*;

  // Command carried on s_tuser
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_DEPART = 1'b1;

  localparam int NUM_SLOTS = NUM_PORTS_DEF * NUM_PRIOS_DEF;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_W_DEF) - 1;
  localparam int unsigned CFG_MAX = 32'h00FF_FFFF;
  localparam int unsigned PROB_MAX = 32'h0001_FFFF;
  localparam int unsigned PROB_ONE = 32'h0001_0000;
  localparam int unsigned PKT_MAX = 16383;
  localparam int unsigned DRAW_MAX = 65535;

  // Expected verdicts typed straight into the directed table
  localparam int PREDICT = -1;  // row is checked against the accounting model
  localparam int V_DROP = 0;    // arrival refused, nothing else raised
  localparam int V_ADMIT = 1;   // admitted (always set on departures), no flags

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 22;
  localparam int FLOOD_ARRIVALS = 1030;
  localparam int FLOOD_DEPARTS = 20;
  localparam int LONG_HOLD = 120;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  in_port;
    logic [5:0]  out_port;
    logic [2:0]  prio;
    logic [13:0] bytes;
    logic [15:0] draw;
  } pkt_t;

  // Same bit order as m_tdata[3:0]: admitted in bit 0
  typedef struct packed {
    logic ecn_mark;
    logic send_resume;
    logic send_pause;
    logic admitted;
  } verdict_t;

  typedef enum bit {ROW_PKT, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    pkt_t        pkt;
    bit          typed;
    verdict_t    want;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
  } step_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  pfc_buffer_admission_ecn_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Accounting model state: settings as the block holds them, and the per-slot
  // counters indexed {port, priority}.
  longint unsigned cfg_reserved = 0;
  longint unsigned cfg_thr      = PAUSE_THR_RST;
  longint unsigned cfg_resume   = RESUME_RST;
  longint unsigned cfg_hdrm     = 0;
  longint unsigned cfg_ecn_min  = 0;
  longint unsigned cfg_ecn_max  = ECN_MAX_RST;
  longint unsigned cfg_prob     = 0;

  longint unsigned ing_cnt[NUM_SLOTS];
  longint unsigned hdrm_cnt[NUM_SLOTS];
  longint unsigned egr_cnt[NUM_SLOTS];
  bit              paused[NUM_SLOTS];

  verdict_t verdict_q[$];      // verdicts still owed by the block, oldest first
  pkt_t     pending_q[$];      // admitted packets not yet sent out again
  step_t    directed_steps[$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  int  n_transfers = 0;
  int  n_drops = 0;
  int  n_pauses = 0;
  int  n_resumes = 0;
  int  n_marks = 0;
  int  n_reg_writes = 0;
  bit  calm = 1'b0;            // no idling on either side
  bit  long_hold_req = 1'b0;   // ask the result side for one long hold-off

  verdict_t got_v;
  verdict_t want_v;
  verdict_t last_v;
  pkt_t     p;
  int       phase;
  int       k;
  int       roll;
  int       idx;
  int unsigned ecn_lo;
  int unsigned ecn_hi;
  logic [5:0] in_pool[4];
  logic [5:0] out_pool[4];

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
    return (a + b > CNT_MAX) ? CNT_MAX : a + b;
  endfunction

  function automatic longint unsigned clamp_sub(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  // Ingress bytes above the guaranteed reserve
  function automatic longint unsigned excess_bytes(int unsigned slot);
    return (ing_cnt[slot] > cfg_reserved) ? ing_cnt[slot] - cfg_reserved : 0;
  endfunction

  // Charge or release one packet and return the verdict the block owes for it.
  function automatic verdict_t account_packet(pkt_t pk);
    int unsigned in_slot;
    int unsigned eg_slot;
    longint unsigned sz;
    longint unsigned nb;
    longint unsigned from_h;
    longint unsigned sh;
    longint unsigned eg;
    longint unsigned span;
    longint unsigned depth;
    bit hdrm_over;
    bit shared_over;
    verdict_t v;
    v = '0;
    v.admitted = pk.cmd;
    sz = pk.bytes;
    in_slot = {pk.in_port, pk.prio};
    eg_slot = {pk.out_port, pk.prio};
    if (pk.cmd == CMD_ARRIVE) begin
      // drop only when both headroom and shared space would overflow
      hdrm_over = sz + hdrm_cnt[in_slot] > cfg_hdrm;
      shared_over = sz + excess_bytes(in_slot) > cfg_thr;
      if (!(hdrm_over && shared_over)) begin
        v.admitted = 1'b1;
        nb = ing_cnt[in_slot] + sz;
        if (nb > cfg_reserved && nb - cfg_reserved > cfg_thr) begin
          hdrm_cnt[in_slot] = sat_add(hdrm_cnt[in_slot], sz);
        end else begin
          ing_cnt[in_slot] = sat_add(ing_cnt[in_slot], sz);
        end
        egr_cnt[eg_slot] = sat_add(egr_cnt[eg_slot], sz);
        if (!paused[in_slot] &&
            (hdrm_cnt[in_slot] != 0 || excess_bytes(in_slot) >= cfg_thr)) begin
          v.send_pause = 1'b1;
          paused[in_slot] = 1'b1;
        end
      end
    end else begin
      // release headroom first, the rest from ingress
      from_h = (hdrm_cnt[in_slot] < sz) ? hdrm_cnt[in_slot] : sz;
      hdrm_cnt[in_slot] = hdrm_cnt[in_slot] - from_h;
      ing_cnt[in_slot] = clamp_sub(ing_cnt[in_slot], sz - from_h);
      egr_cnt[eg_slot] = clamp_sub(egr_cnt[eg_slot], sz);
      sh = excess_bytes(in_slot);
      if (paused[in_slot] && hdrm_cnt[in_slot] == 0 && (sh == 0 || sh + cfg_resume <= cfg_thr)) begin
        v.send_resume = 1'b1;
        paused[in_slot] = 1'b0;
      end
      // RED decision; priority 0 is never marked
      eg = egr_cnt[eg_slot];
      if (pk.prio != 0) begin
        if (eg > cfg_ecn_max) begin
          v.ecn_mark = 1'b1;
        end else if (eg > cfg_ecn_min) begin
          span = cfg_ecn_max - cfg_ecn_min;
          depth = eg - cfg_ecn_min;
          v.ecn_mark = (longint'(pk.draw) * span < cfg_prob * depth);
        end
      end
    end
    return v;
  endfunction

  function automatic step_t pkt_row(logic cmd, int ip, int op, int pr, int nb, int dr, int want);
    step_t s;
    s.kind = ROW_PKT;
    s.pkt.cmd = cmd;
    s.pkt.in_port = 6'(ip);
    s.pkt.out_port = 6'(op);
    s.pkt.prio = 3'(pr);
    s.pkt.bytes = 14'(nb);
    s.pkt.draw = 16'(dr);
    s.typed = (want != PREDICT);
    s.want = verdict_t'(4'(want));
    s.reg_idx = '0;
    s.reg_val = '0;
    return s;
  endfunction

  function automatic step_t reg_row(logic [2:0] ridx, int unsigned val);
    step_t s;
    s.kind = ROW_REG;
    s.pkt = '0;
    s.typed = 1'b0;
    s.want = '0;
    s.reg_idx = ridx;
    s.reg_val = val;
    return s;
  endfunction

  // Offer one packet, hold it until the transfer, then book the verdict owed.
  // Called just after the clock rises, with no pending drive on s_tvalid.
  task automatic push_item(input pkt_t pk, input bit typed, input verdict_t want,
                           output verdict_t v);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, pk.draw, pk.bytes, pk.prio, pk.out_port, pk.in_port};
    s_tuser  <= pk.cmd;
    do @(posedge clk); while (!s_tready);
    v = account_packet(pk);
    verdict_q.push_back(typed ? want : v);
    n_transfers++;
    if (!v.admitted) n_drops++;
    if (v.send_pause) n_pauses++;
    if (v.send_resume) n_resumes++;
    if (v.ecn_mark) n_marks++;
  endtask

  // Drop valid and wait until every owed verdict has come back.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then idle with psel low; the model follows the write.
  task automatic reg_write(input logic [2:0] ridx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ridx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (ridx)
      REG_RESERVED:  cfg_reserved = val[CFG_W-1:0];
      REG_PAUSE_THR: cfg_thr      = val[CFG_W-1:0];
      REG_RESUME:    cfg_resume   = val[CFG_W-1:0];
      REG_HDRM_LIM:  cfg_hdrm     = val[CFG_W-1:0];
      REG_ECN_MIN:   cfg_ecn_min  = val[CFG_W-1:0];
      REG_ECN_MAX:   cfg_ecn_max  = val[CFG_W-1:0];
      REG_ECN_PROB:  cfg_prob     = val[PROB_W-1:0];
      default: ;
    endcase
    n_reg_writes++;
    @(posedge clk);
  endtask

  // Drain the block, then load a complete register set.
  task automatic apply_settings(input int unsigned res, input int unsigned thr,
                                input int unsigned resm, input int unsigned hdrm,
                                input int unsigned mn, input int unsigned mx,
                                input int unsigned prob);
    quiesce();
    reg_write(REG_RESERVED, res);
    reg_write(REG_PAUSE_THR, thr);
    reg_write(REG_RESUME, resm);
    reg_write(REG_HDRM_LIM, hdrm);
    reg_write(REG_ECN_MIN, mn);
    reg_write(REG_ECN_MAX, mx);
    reg_write(REG_ECN_PROB, prob);
  endtask

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("[%0t] %s: got adm=%b pause=%b resume=%b mark=%b, want adm=%b pause=%b resume=%b mark=%b",
               $realtime, what, got_v.admitted, got_v.send_pause, got_v.send_resume,
               got_v.ecn_mark, want_v.admitted, want_v.send_pause, want_v.send_resume,
               want_v.ecn_mark);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cycle budget: end the run if the block stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count, verdict_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Result side: short random stalls, plus one long hold-off on request so the
  // block backs up and holds s_tready low while packets keep being offered.
  initial begin
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Check each result transfer against the oldest owed verdict.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_v = verdict_t'(m_tdata[3:0]);
      results_seen++;
      if (verdict_q.size() == 0) begin
        want_v = 'x;
        report("result with nothing owed");
      end else begin
        want_v = verdict_q.pop_front();
        if (got_v !== want_v) report("verdict mismatch");
      end
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= CMD_ARRIVE;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table, starting from reset settings (threshold 5241, no headroom,
    // marking probability zero). The first packet waits out the clearing pass.
    directed_steps.push_back(pkt_row(CMD_ARRIVE, 0, 0, 0, 0, 0, V_ADMIT));
    // full-size arrival with no headroom and over the threshold: dropped
    directed_steps.push_back(pkt_row(CMD_ARRIVE, 63, 63, 7, PKT_MAX, DRAW_MAX, V_DROP));
    // departure from an empty slot: every counter clamps at zero
    directed_steps.push_back(pkt_row(CMD_DEPART, 63, 63, 7, PKT_MAX, DRAW_MAX, V_ADMIT));
    directed_steps.push_back(pkt_row(CMD_ARRIVE, 1, 2, 3, 5000, 16'h5555, PREDICT));
    // shared use lands exactly on the threshold: pause
    directed_steps.push_back(pkt_row(CMD_ARRIVE, 1, 2, 3, 241, 0, PREDICT));
    directed_steps.push_back(pkt_row(CMD_ARRIVE, 1, 2, 3, 1, 0, PREDICT));
    directed_steps.push_back(reg_row(REG_HDRM_LIM, 20000));
    // now charged to headroom
    directed_steps.push_back(pkt_row(CMD_ARRIVE, 1, 2, 3, 3000, 0, PREDICT));
    directed_steps.push_back(pkt_row(CMD_DEPART, 1, 2, 3, 2000, 0, PREDICT));
    directed_steps.push_back(pkt_row(CMD_DEPART, 1, 2, 3, 5000, 0, PREDICT));
    // slot drains to zero: resume
    directed_steps.push_back(pkt_row(CMD_DEPART, 1, 2, 3, 1241, 0, PREDICT));
    directed_steps.push_back(reg_row(REG_ECN_MIN, 1000));
    directed_steps.push_back(reg_row(REG_ECN_MAX, 9000));
    directed_steps.push_back(reg_row(REG_ECN_PROB, PROB_ONE));
    directed_steps.push_back(pkt_row(CMD_ARRIVE, 4, 5, 1, 8000, 0, PREDICT));
    // RED band: high draw passes, zero draw marks
    directed_steps.push_back(pkt_row(CMD_DEPART, 4, 5, 1, 0, DRAW_MAX, PREDICT));
    directed_steps.push_back(pkt_row(CMD_DEPART, 4, 5, 1, 0, 0, PREDICT));
    // priority 0 deep over max depth, still never marked
    directed_steps.push_back(pkt_row(CMD_ARRIVE, 6, 5, 0, 9500, 0, PREDICT));
    directed_steps.push_back(pkt_row(CMD_DEPART, 6, 5, 0, 100, 0, PREDICT));
    // egress above max depth: forced mark
    directed_steps.push_back(pkt_row(CMD_ARRIVE, 7, 5, 1, 2000, 0, PREDICT));
    directed_steps.push_back(pkt_row(CMD_DEPART, 4, 5, 1, 500, 16'hAAAA, PREDICT));
    // probability above one, largest draw
    directed_steps.push_back(reg_row(REG_ECN_PROB, PROB_MAX));
    directed_steps.push_back(pkt_row(CMD_DEPART, 7, 5, 1, 1000, DRAW_MAX, PREDICT));
    directed_steps.push_back(reg_row(REG_RESERVED, CFG_MAX));
    directed_steps.push_back(reg_row(REG_PAUSE_THR, CFG_MAX));
    directed_steps.push_back(reg_row(REG_RESUME, 0));
    directed_steps.push_back(pkt_row(CMD_ARRIVE, 0, 63, 7, PKT_MAX, 0, PREDICT));
    directed_steps.push_back(pkt_row(CMD_DEPART, 0, 63, 7, PKT_MAX, 0, PREDICT));

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == ROW_REG) begin
        quiesce();
        reg_write(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      end else begin
        push_item(directed_steps[i].pkt, directed_steps[i].typed, directed_steps[i].want, last_v);
      end
    end

    // Flood one slot with full-size packets until ingress and egress saturate.
    // A reserve of one packet keeps the charge on ingress past the top.
    apply_settings(PKT_MAX, CFG_MAX, 0, CFG_MAX, 0, 32'h0080_0000, PROB_ONE);
    p = '0;
    p.in_port = 6'd9;
    p.out_port = 6'd9;
    p.prio = 3'd5;
    p.bytes = 14'(PKT_MAX);
    for (k = 0; k < FLOOD_ARRIVALS + FLOOD_DEPARTS; k++) begin
      p.cmd = (k < FLOOD_ARRIVALS) ? CMD_ARRIVE : CMD_DEPART;
      p.draw = 16'($urandom_range(0, DRAW_MAX));
      push_item(p, 1'b0, '0, last_v);
    end

    // Random phases: each loads a register set (all-zero and all-max first),
    // then mostly arrivals and matching departures on a few busy ports, with
    // some unmatched noise. The last phase runs without idling.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        apply_settings(0, 0, 0, 0, 0, 0, 0);
      end else if (phase == 1) begin
        apply_settings(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, PROB_MAX);
      end else begin
        ecn_lo = $urandom_range(0, 20000);
        ecn_hi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ecn_lo)
                                             : ecn_lo + $urandom_range(0, 40000);
        apply_settings($urandom_range(0, 8000), $urandom_range(0, 20000),
                       $urandom_range(0, 20000), $urandom_range(0, 30000), ecn_lo, ecn_hi,
                       ($urandom_range(0, 3) == 0) ? PROB_ONE : $urandom_range(0, PROB_MAX));
      end
      calm = (phase == RANDOM_PHASES - 1);
      foreach (in_pool[j]) begin
        in_pool[j] = 6'($urandom_range(0, NUM_PORTS_DEF - 1));
        out_pool[j] = 6'($urandom_range(0, NUM_PORTS_DEF - 1));
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 3 && k == 20) long_hold_req = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          // noise: any field value, departures unmatched
          p.cmd = 1'($urandom_range(0, 1));
          p.in_port = 6'($urandom_range(0, NUM_PORTS_DEF - 1));
          p.out_port = 6'($urandom_range(0, NUM_PORTS_DEF - 1));
          p.prio = 3'($urandom_range(0, NUM_PRIOS_DEF - 1));
          p.bytes = 14'($urandom_range(0, PKT_MAX));
        end else if ((roll < 55 && pending_q.size() != 0) || pending_q.size() > 48) begin
          // release a packet that was admitted earlier
          idx = $urandom_range(0, pending_q.size() - 1);
          p = pending_q[idx];
          pending_q.delete(idx);
          p.cmd = CMD_DEPART;
        end else begin
          p.cmd = CMD_ARRIVE;
          p.in_port = in_pool[$urandom_range(0, 3)];
          p.out_port = out_pool[$urandom_range(0, 3)];
          p.prio = 3'($urandom_range(0, NUM_PRIOS_DEF - 1));
          roll = $urandom_range(0, 15);
          p.bytes = (roll == 0) ? 14'd0 : (roll == 1) ? 14'(PKT_MAX)
                                         : 14'($urandom_range(64, 3000));
        end
        p.draw = 16'($urandom_range(0, DRAW_MAX));
        push_item(p, 1'b0, '0, last_v);
        if (p.cmd == CMD_ARRIVE && last_v.admitted) pending_q.push_back(p);
      end
    end

    // All packets offered: drain, then watch a little longer for stray results.
    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d packet transfers and %0d register writes over %0d phases",
             n_transfers, n_reg_writes, RANDOM_PHASES + 2);
    $display("verdicts: %0d drops, %0d pauses, %0d resumes, %0d ECN marks, %0d mismatches",
             n_drops, n_pauses, n_resumes, n_marks, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== pfc_buffer_admission_ecn_unit.f =====
rtl/core/pfcba_pkg.sv
rtl/core/pfcba_ram.sv
rtl/core/pfcba_regs.sv
rtl/core/pfcba_ecn.sv
rtl/core/pfc_buffer_admission_ecn_unit.sv
sim/testbench.sv
